// File: rtl/srsw_pkg.sv
package srsw_pkg;

  localparam int RES_MAX     = 16;
  localparam int WIN_MAX_DEF = 16;

  localparam int SEQ_W   = 32;
  localparam int CNT_W   = 5;
  localparam int AGE_W   = 8;
  localparam int RETX_W  = 4;
  localparam int WSIZE_W = 5;
  localparam int TMO_W   = 8;
  localparam int EV_W    = 3;
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd4;
  localparam logic [TMO_W-1:0]   TMO_RST   = 8'd3;
  localparam logic [RETX_W-1:0]  MAXR_RST  = 4'd5;
  localparam logic [SEQ_W-1:0]   START_RST = 32'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } srsw_mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE = 3'd0,
    EV_SENT = 3'd1,
    EV_RETX = 3'd2,
    EV_FAIL = 3'd3,
    EV_FULL = 3'd4
  } srsw_ev_t;

  typedef enum logic [1:0] {
    REG_WSIZE = 2'd0,
    REG_TMO   = 2'd1,
    REG_MAXR  = 2'd2,
    REG_START = 2'd3
  } srsw_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK_RD,
    S_ACK_WR,
    S_SLIDE_RD,
    S_SLIDE_CHK,
    S_TICK_RD,
    S_TICK_EV,
    S_FINAL
  } srsw_state_t;

  typedef struct packed {
    logic              acked;
    logic [AGE_W-1:0]  age;
    logic [RETX_W-1:0] retx;
  } srsw_entry_t;

endpackage

// File: rtl/srsw_mem.sv
module srsw_mem #(
  parameter int DEPTH  = srsw_pkg::WIN_MAX_DEF,
  parameter int IDX_W  = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  srsw_pkg::srsw_entry_t wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output srsw_pkg::srsw_entry_t rdata
);

  srsw_pkg::srsw_entry_t mem_r [DEPTH];
  srsw_pkg::srsw_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/selective_repeat_send_window_core.sv
// From accept to the output register: send, full and unused mode go to the final state; tick
// reads and updates each outstanding packet; ack does a lookup, a write when it marks a packet,
// a read and check per packet the base slides over, a read and check of the new head (only the
// read step once empty) and the final state. in_ready is high only while the sequencer is idle;
// each stall on a waiting word lengthens the item. rst_n (synchronous) clears control state
// and registers; the entry memory is not cleared, as an entry is written on admission.
module selective_repeat_send_window_core #(
  parameter int WIN_MAX = srsw_pkg::WIN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srsw_pkg::MODE_W-1:0]   in_mode,
  input  logic [srsw_pkg::SEQ_W-1:0]    in_ack_number,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srsw_pkg::EV_W-1:0]     out_event_res,
  output logic [srsw_pkg::SEQ_W-1:0]    out_packet_seq,
  output logic                          out_last,
  output logic [srsw_pkg::SEQ_W-1:0]    out_window_base,
  output logic [srsw_pkg::SEQ_W-1:0]    out_next_number,
  output logic                          out_window_empty,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsw_pkg::DATA_W-1:0]   pwdata,
  output logic [srsw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(WIN_MAX);
  localparam int LIM   = (WIN_MAX < srsw_pkg::RES_MAX) ? WIN_MAX : srsw_pkg::RES_MAX;
  localparam int SEQ_W = srsw_pkg::SEQ_W;
  localparam int CNT_W = srsw_pkg::CNT_W;

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(WIN_MAX)) s = s - (IDX_W+1)'(WIN_MAX);
    return s[IDX_W-1:0];
  endfunction

  srsw_pkg::srsw_state_t state_r, state_nxt;

  logic [SEQ_W-1:0]               base_r, base_nxt;
  logic [SEQ_W-1:0]               next_r, next_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [IDX_W-1:0]               ptr_r, ptr_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [SEQ_W-1:0]               ack_r, ack_nxt;
  logic [IDX_W-1:0]               ack_idx_r, ack_idx_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  srsw_pkg::srsw_ev_t             pend_ev_r, pend_ev_nxt;
  logic [SEQ_W-1:0]               pend_seq_r, pend_seq_nxt;

  logic                           out_valid_r, out_valid_nxt;
  srsw_pkg::srsw_ev_t             out_ev_r, out_ev_nxt;
  logic [SEQ_W-1:0]               out_seq_r, out_seq_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [SEQ_W-1:0]               out_base_r, out_base_nxt;
  logic [SEQ_W-1:0]               out_next_r, out_next_nxt;
  logic                           out_empty_r, out_empty_nxt;

  logic [srsw_pkg::WSIZE_W-1:0]   wsize_r, wsize_nxt;
  logic [srsw_pkg::TMO_W-1:0]     tmo_r, tmo_nxt;
  logic [srsw_pkg::RETX_W-1:0]    maxr_r, maxr_nxt;
  logic [SEQ_W-1:0]               start_r, start_nxt;

  logic                           mem_we, mem_re;
  logic [IDX_W-1:0]               mem_waddr, mem_raddr;
  srsw_pkg::srsw_entry_t          mem_wdata, ent;

  logic                           in_fire, slot_free, cfg_wr;
  logic [SEQ_W-1:0]               off;
  logic                           ack_hit, send_ok;
  logic [srsw_pkg::AGE_W-1:0]     age_inc;
  logic [srsw_pkg::RETX_W-1:0]    retx_inc;
  logic                           timed, failed, tick_hit, tick_go, idx_last;
  logic                           out_load, ld_last;
  srsw_pkg::srsw_ev_t             ld_ev;
  logic [SEQ_W-1:0]               ld_seq;

  srsw_mem #(
    .DEPTH (WIN_MAX),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  assign in_ready  = (state_r == srsw_pkg::S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign slot_free = ~out_valid_r | out_ready;
  assign cfg_wr    = psel & penable & pwrite;
  assign pready    = 1'b1;

  assign off      = ack_r - base_r;
  assign ack_hit  = off < SEQ_W'(cnt_r);
  assign send_ok  = (cnt_r < wsize_r) && (cnt_r < CNT_W'(LIM));
  assign age_inc  = (ent.age == '1) ? ent.age : ent.age + 1'b1;
  assign retx_inc = (ent.retx == '1) ? ent.retx : ent.retx + 1'b1;
  assign timed    = age_inc > tmo_r;
  assign failed   = ent.retx > maxr_r;
  assign tick_hit = ~ent.acked & timed;
  assign tick_go  = ~(tick_hit & pend_valid_r & ~slot_free);
  assign idx_last = (CNT_W'(idx_r + 1'b1) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srsw_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (srsw_pkg::srsw_mode_t'(in_mode))
            srsw_pkg::MODE_ACK:  state_nxt = srsw_pkg::S_ACK_RD;
            srsw_pkg::MODE_TICK: state_nxt = (cnt_r == '0) ? srsw_pkg::S_FINAL
                                                           : srsw_pkg::S_TICK_RD;
            srsw_pkg::MODE_SEND,
            srsw_pkg::MODE_NONE: state_nxt = srsw_pkg::S_FINAL;
            default:             state_nxt = srsw_pkg::S_FINAL;
          endcase
        end
      end
      srsw_pkg::S_ACK_RD:    state_nxt = ack_hit ? srsw_pkg::S_ACK_WR : srsw_pkg::S_SLIDE_RD;
      srsw_pkg::S_ACK_WR:    state_nxt = srsw_pkg::S_SLIDE_RD;
      srsw_pkg::S_SLIDE_RD:  state_nxt = (cnt_r == '0) ? srsw_pkg::S_FINAL
                                                       : srsw_pkg::S_SLIDE_CHK;
      srsw_pkg::S_SLIDE_CHK: state_nxt = ent.acked ? srsw_pkg::S_SLIDE_RD : srsw_pkg::S_FINAL;
      srsw_pkg::S_TICK_RD:   state_nxt = srsw_pkg::S_TICK_EV;
      srsw_pkg::S_TICK_EV: begin
        if (tick_go) begin
          state_nxt = idx_last ? srsw_pkg::S_FINAL : srsw_pkg::S_TICK_RD;
        end
      end
      srsw_pkg::S_FINAL:     state_nxt = slot_free ? srsw_pkg::S_IDLE : srsw_pkg::S_FINAL;
      default:               state_nxt = srsw_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    base_nxt       = base_r;
    next_nxt       = next_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    ack_nxt        = ack_r;
    ack_idx_nxt    = ack_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_ev_nxt    = pend_ev_r;
    pend_seq_nxt   = pend_seq_r;
    wsize_nxt      = wsize_r;
    tmo_nxt        = tmo_r;
    maxr_nxt       = maxr_r;
    start_nxt      = start_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    out_load       = 1'b0;
    ld_ev          = srsw_pkg::EV_NONE;
    ld_seq         = base_r;
    ld_last        = 1'b0;

    unique case (state_r)
      srsw_pkg::S_IDLE: begin
        if (in_fire) begin
          ack_nxt        = in_ack_number;
          pend_valid_nxt = 1'b0;
          ptr_nxt        = head_r;
          idx_nxt        = '0;
          unique case (srsw_pkg::srsw_mode_t'(in_mode))
            srsw_pkg::MODE_SEND: begin
              pend_valid_nxt = 1'b1;
              pend_seq_nxt   = next_r;
              if (send_ok) begin
                mem_we      = 1'b1;
                mem_waddr   = idx_add(head_r, IDX_W'(cnt_r));
                next_nxt    = next_r + 1'b1;
                cnt_nxt     = cnt_r + 1'b1;
                pend_ev_nxt = srsw_pkg::EV_SENT;
              end else begin
                pend_ev_nxt = srsw_pkg::EV_FULL;
              end
            end
            srsw_pkg::MODE_ACK: begin
              pend_valid_nxt = 1'b1;
              pend_ev_nxt    = srsw_pkg::EV_NONE;
              pend_seq_nxt   = in_ack_number;
            end
            srsw_pkg::MODE_TICK,
            srsw_pkg::MODE_NONE: begin
              pend_valid_nxt = 1'b0;
            end
            default: begin
              pend_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      srsw_pkg::S_ACK_RD: begin
        if (ack_hit) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_add(head_r, off[IDX_W-1:0]);
          ack_idx_nxt = mem_raddr;
        end
      end
      srsw_pkg::S_ACK_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = ack_idx_r;
        mem_wdata       = ent;
        mem_wdata.acked = 1'b1;
      end
      srsw_pkg::S_SLIDE_RD: begin
        if (cnt_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = head_r;
        end
      end
      srsw_pkg::S_SLIDE_CHK: begin
        if (ent.acked) begin
          head_nxt = idx_add(head_r, IDX_W'(1));
          base_nxt = base_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      srsw_pkg::S_TICK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
      end
      srsw_pkg::S_TICK_EV: begin
        if (tick_go) begin
          ptr_nxt = idx_add(ptr_r, IDX_W'(1));
          idx_nxt = idx_r + 1'b1;
          if (!ent.acked) begin
            mem_we          = 1'b1;
            mem_waddr       = ptr_r;
            mem_wdata.acked = 1'b0;
            if (timed && !failed) begin
              mem_wdata.age  = '0;
              mem_wdata.retx = retx_inc;
            end else begin
              mem_wdata.age  = age_inc;
              mem_wdata.retx = ent.retx;
            end
          end
          if (tick_hit) begin
            if (pend_valid_r) begin
              out_load = 1'b1;
              ld_ev    = pend_ev_r;
              ld_seq   = pend_seq_r;
            end
            pend_valid_nxt = 1'b1;
            pend_ev_nxt    = failed ? srsw_pkg::EV_FAIL : srsw_pkg::EV_RETX;
            pend_seq_nxt   = base_r + SEQ_W'(idx_r);
          end
        end
      end
      srsw_pkg::S_FINAL: begin
        if (slot_free) begin
          out_load       = 1'b1;
          ld_last        = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            ld_ev  = pend_ev_r;
            ld_seq = pend_seq_r;
          end
        end
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase

    if (cfg_wr) begin
      unique case (srsw_pkg::srsw_reg_t'(paddr[3:2]))
        srsw_pkg::REG_WSIZE: wsize_nxt = pwdata[srsw_pkg::WSIZE_W-1:0];
        srsw_pkg::REG_TMO:   tmo_nxt   = pwdata[srsw_pkg::TMO_W-1:0];
        srsw_pkg::REG_MAXR:  maxr_nxt  = pwdata[srsw_pkg::RETX_W-1:0];
        srsw_pkg::REG_START: begin
          start_nxt = pwdata;
          base_nxt  = pwdata;
          next_nxt  = pwdata;
          cnt_nxt   = '0;
          head_nxt  = '0;
        end
        default: start_nxt = start_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ev_nxt    = out_ev_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    out_base_nxt  = out_base_r;
    out_next_nxt  = out_next_r;
    out_empty_nxt = out_empty_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_ev_nxt    = ld_ev;
      out_seq_nxt   = ld_seq;
      out_last_nxt  = ld_last;
      out_base_nxt  = base_r;
      out_next_nxt  = next_r;
      out_empty_nxt = (cnt_r == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    unique case (srsw_pkg::srsw_reg_t'(paddr[3:2]))
      srsw_pkg::REG_WSIZE: prdata = srsw_pkg::DATA_W'(wsize_r);
      srsw_pkg::REG_TMO:   prdata = srsw_pkg::DATA_W'(tmo_r);
      srsw_pkg::REG_MAXR:  prdata = srsw_pkg::DATA_W'(maxr_r);
      srsw_pkg::REG_START: prdata = start_r;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srsw_pkg::S_IDLE;
      base_r       <= srsw_pkg::START_RST;
      next_r       <= srsw_pkg::START_RST;
      cnt_r        <= '0;
      head_r       <= '0;
      ptr_r        <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      wsize_r      <= srsw_pkg::WSIZE_RST;
      tmo_r        <= srsw_pkg::TMO_RST;
      maxr_r       <= srsw_pkg::MAXR_RST;
      start_r      <= srsw_pkg::START_RST;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      next_r       <= next_nxt;
      cnt_r        <= cnt_nxt;
      head_r       <= head_nxt;
      ptr_r        <= ptr_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      wsize_r      <= wsize_nxt;
      tmo_r        <= tmo_nxt;
      maxr_r       <= maxr_nxt;
      start_r      <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ack_r       <= ack_nxt;
    ack_idx_r   <= ack_idx_nxt;
    pend_ev_r   <= pend_ev_nxt;
    pend_seq_r  <= pend_seq_nxt;
    out_ev_r    <= out_ev_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
    out_base_r  <= out_base_nxt;
    out_next_r  <= out_next_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_packet_seq   = out_seq_r;
  assign out_last         = out_last_r;
  assign out_window_base  = out_base_r;
  assign out_next_number  = out_next_r;
  assign out_window_empty = out_empty_r;

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r - base_r) == SEQ_W'(cnt_r))
    else $error("outstanding count out of step with base and next");

  a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LIM))
    else $error("outstanding count beyond window limit");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srsw_pkg::S_IDLE) |-> !pend_valid_r)
    else $error("pending word left over when idle");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("entry memory read and write collide");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (IDX_W+1)'(WIN_MAX))
    else $error("head pointer beyond window depth");

endmodule
